// File: design/bdll_pkg.sv
`default_nettype none

package bdll_pkg;

    // widths of the item fields
    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    // default pool size and dump length limit
    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_A,
        S_APP_B,
        S_SEARCH,
        S_WALK,
        S_INS_A,
        S_INS_B,
        S_DEL,
        S_DUMP,
        S_DUMP_WALK,
        S_RESP
    } t_state;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SRCH_START,
        DP_SRCH_STEP,
        DP_APP_A,
        DP_APP_B,
        DP_INS_A,
        DP_INS_B,
        DP_DEL,
        DP_EMIT_ITEM,
        DP_EMIT_STATUS
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic head_nil;
        logic match;
        logic walk_end;
        logic free_none;
        logic out_free;
        logic dump_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: design/bdll_if.sv
`default_nettype none

// input channel: one command item
interface bdll_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic signed [31:0] key;
    logic signed [31:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

// output channel: one result item
interface bdll_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] item;
    logic        last;

    modport source (output valid, output status, output item, output last, input ready);
    modport sink   (input valid, input status, input item, input last, output ready);
endinterface

`default_nettype wire

// File: design/bdll_dp.sv
`default_nettype none

module bdll_dp import bdll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_ctl                  i_ctl,
    output t_dp_stat                 o_stat,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [DATA_W-1:0] i_key,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_item,
    output logic                     o_last
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [IW-1:0] NIL = IW'(CAPACITY);

    // latched command
    t_cmd                r_cmd;
    logic [DATA_W-1:0]   r_key;
    logic [DATA_W-1:0]   r_val;

    // list control state
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [IW-1:0]       r_cur, n_cur;
    logic [IW-1:0]       r_steps, n_steps;
    logic [AW-1:0]       r_new;

    // node pool
    logic [DATA_W-1:0]   r_value_mem [CAPACITY];
    logic [IW-1:0]       r_next_mem  [CAPACITY];
    logic [IW-1:0]       r_prev_mem  [CAPACITY];
    logic [DATA_W-1:0]   r_rd_value;
    logic [IW-1:0]       r_rd_next;
    logic [IW-1:0]       r_rd_prev;

    // output register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status;
    logic [DATA_W-1:0]   r_out_item;
    logic                r_out_last;

    logic                out_load;
    t_status             out_status;
    logic [DATA_W-1:0]   out_item;
    logic                out_last;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                value_we, next_we, prev_we;
    logic [AW-1:0]       value_addr, next_addr, prev_addr;
    logic [IW-1:0]       next_data, prev_data;

    logic [AW-1:0]       free_idx;
    logic                free_none;
    logic                head_nil, tail_nil, rd_next_nil, rd_prev_nil;
    logic                steps_full, dump_last, out_free;

    // lowest unused entry
    always_comb begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) free_idx = AW'(i);
        end
    end

    assign free_none   = &r_used;
    assign head_nil    = (r_head >= NIL);
    assign tail_nil    = (r_tail >= NIL);
    assign rd_next_nil = (r_rd_next >= NIL);
    assign rd_prev_nil = (r_rd_prev >= NIL);
    assign steps_full  = (r_steps >= NIL);
    assign dump_last   = rd_next_nil || steps_full || (32'(r_steps) >= MAX_RESULTS);
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_stat.cmd       = r_cmd;
    assign o_stat.head_nil  = head_nil;
    assign o_stat.match     = (r_rd_value == r_key);
    assign o_stat.walk_end  = rd_next_nil || steps_full;
    assign o_stat.free_none = free_none;
    assign o_stat.out_free  = out_free;
    assign o_stat.dump_last = dump_last;

    // operation decode
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_used     = r_used;
        n_cur      = r_cur;
        n_steps    = r_steps;
        rd_en      = 1'b0;
        rd_addr    = r_rd_next[AW-1:0];
        value_we   = 1'b0;
        next_we    = 1'b0;
        prev_we    = 1'b0;
        value_addr = free_idx;
        next_addr  = free_idx;
        prev_addr  = free_idx;
        next_data  = NIL;
        prev_data  = NIL;
        out_load   = 1'b0;
        out_status = ST_OK;
        out_item   = '0;
        out_last   = 1'b1;
        unique case (i_ctl.op)
            DP_NOP, DP_LOAD: begin
            end
            DP_SRCH_START: begin
                rd_en   = 1'b1;
                rd_addr = r_head[AW-1:0];
                n_cur   = r_head;
                n_steps = IW'(1);
            end
            DP_SRCH_STEP: begin
                rd_en   = 1'b1;
                n_cur   = r_rd_next;
                n_steps = r_steps + IW'(1);
            end
            DP_APP_A: begin
                value_we  = 1'b1;
                next_we   = 1'b1;
                next_data = NIL;
                prev_we   = 1'b1;
                prev_data = r_tail;
            end
            DP_APP_B: begin
                if (tail_nil) begin
                    n_head = IW'(r_new);
                end else begin
                    next_we   = 1'b1;
                    next_addr = r_tail[AW-1:0];
                    next_data = IW'(r_new);
                end
                n_tail        = IW'(r_new);
                n_used[r_new] = 1'b1;
            end
            DP_INS_A: begin
                value_we  = 1'b1;
                next_we   = 1'b1;
                next_data = r_cur;
                prev_we   = 1'b1;
                prev_data = r_rd_prev;
            end
            DP_INS_B: begin
                if (rd_prev_nil) begin
                    n_head = IW'(r_new);
                end else begin
                    next_we   = 1'b1;
                    next_addr = r_rd_prev[AW-1:0];
                    next_data = IW'(r_new);
                end
                prev_we       = 1'b1;
                prev_addr     = r_cur[AW-1:0];
                prev_data     = IW'(r_new);
                n_used[r_new] = 1'b1;
            end
            DP_DEL: begin
                if (rd_prev_nil) begin
                    n_head = r_rd_next;
                end else begin
                    next_we   = 1'b1;
                    next_addr = r_rd_prev[AW-1:0];
                    next_data = r_rd_next;
                end
                if (rd_next_nil) begin
                    n_tail = r_rd_prev;
                end else begin
                    prev_we   = 1'b1;
                    prev_addr = r_rd_next[AW-1:0];
                    prev_data = r_rd_prev;
                end
                n_used[r_cur[AW-1:0]] = 1'b0;
            end
            DP_EMIT_ITEM: begin
                out_load   = 1'b1;
                out_status = ST_OK;
                out_item   = r_rd_value;
                out_last   = dump_last;
                if (!dump_last) begin
                    rd_en   = 1'b1;
                    n_cur   = r_rd_next;
                    n_steps = r_steps + IW'(1);
                end
            end
            DP_EMIT_STATUS: begin
                out_load   = 1'b1;
                out_status = i_ctl.status;
            end
            default: begin
            end
        endcase
    end

    // output valid tracking
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NIL;
            r_tail      <= NIL;
            r_used      <= '0;
            r_cur       <= NIL;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_used      <= n_used;
            r_cur       <= n_cur;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.op == DP_LOAD) begin
            r_cmd <= t_cmd'(i_command);
            r_key <= i_key;
            r_val <= i_value;
        end
        if (i_ctl.op == DP_APP_A || i_ctl.op == DP_INS_A) begin
            r_new <= free_idx;
        end
        if (out_load) begin
            r_out_status <= out_status;
            r_out_item   <= out_item;
            r_out_last   <= out_last;
        end
    end

    // node pool write ports
    always_ff @(posedge i_clk) begin
        if (value_we) r_value_mem[value_addr] <= r_val;
        if (next_we)  r_next_mem[next_addr]   <= next_data;
        if (prev_we)  r_prev_mem[prev_addr]   <= prev_data;
    end

    // node pool registered read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_value <= r_value_mem[rd_addr];
            r_rd_next  <= r_next_mem[rd_addr];
            r_rd_prev  <= r_prev_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_item      = r_out_item;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

// File: design/bdll_ctrl.sv
`default_nettype none

module bdll_ctrl import bdll_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_in_ready,
    input  t_dp_stat         i_stat,
    output t_dp_ctl          o_ctl
);

    t_state  r_state, n_state;
    t_status r_status, n_status;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (t_cmd'(i_command))
                        CMD_APPEND: n_state = S_APP_A;
                        CMD_INSERT, CMD_DELETE: n_state = S_SEARCH;
                        default: n_state = S_DUMP;
                    endcase
                end
            end
            S_APP_A: begin
                if (i_stat.free_none) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_APP_B;
                end
            end
            S_APP_B, S_INS_B, S_DEL: begin
                n_status = ST_OK;
                n_state  = S_RESP;
            end
            S_SEARCH: begin
                if (i_stat.head_nil) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_stat.match) begin
                    n_state = (i_stat.cmd == CMD_INSERT) ? S_INS_A : S_DEL;
                end else if (i_stat.walk_end) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end
            end
            S_INS_A: begin
                if (i_stat.free_none) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_INS_B;
                end
            end
            S_DUMP: begin
                if (i_stat.head_nil) begin
                    n_status = ST_EMPTY;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_DUMP_WALK;
                end
            end
            S_DUMP_WALK: begin
                if (i_stat.out_free && i_stat.dump_last) n_state = S_IDLE;
            end
            S_RESP: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_in_ready   = 1'b0;
        o_ctl.op     = DP_NOP;
        o_ctl.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctl.op = DP_LOAD;
            end
            S_APP_A: begin
                if (!i_stat.free_none) o_ctl.op = DP_APP_A;
            end
            S_APP_B: o_ctl.op = DP_APP_B;
            S_SEARCH, S_DUMP: begin
                if (!i_stat.head_nil) o_ctl.op = DP_SRCH_START;
            end
            S_WALK: begin
                if (!i_stat.match && !i_stat.walk_end) o_ctl.op = DP_SRCH_STEP;
            end
            S_INS_A: begin
                if (!i_stat.free_none) o_ctl.op = DP_INS_A;
            end
            S_INS_B: o_ctl.op = DP_INS_B;
            S_DEL:   o_ctl.op = DP_DEL;
            S_DUMP_WALK: begin
                if (i_stat.out_free) o_ctl.op = DP_EMIT_ITEM;
            end
            S_RESP: begin
                if (i_stat.out_free) o_ctl.op = DP_EMIT_STATUS;
            end
            default: o_ctl.op = DP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: design/bounded_doubly_linked_list.sv
// Bounded doubly linked list of signed 32-bit values in a pool of CAPACITY nodes.
// i_in carries command items (append, insert before key, delete key, dump);
// o_out carries result items (status, item, last). Both are valid/ready channels.
// Commands are handled one at a time: i_in.ready is high only while the
// controller waits for a new command.
// After accept, append runs S_APP_A and S_APP_B and then S_RESP (a full pool goes
// from S_APP_A straight to S_RESP); insert and delete run S_SEARCH and one S_WALK
// step per node walked, then S_INS_A and S_INS_B or S_DEL, then S_RESP; insert
// into a full pool stops at S_INS_A, a miss at the end of the walk and an empty
// list at S_SEARCH. Dump passes S_DUMP and then shows one value per cycle while
// the receiver takes them, up to min(CAPACITY, 16) values.
// The walk through the node pool makes one registered read per node.
// Reset clears the used marks and sets head and tail to the empty marker; node
// contents are not cleared. The block accepts commands as soon as reset is
// released.
// Results sit in an output register; when the receiver stalls, the register and
// the dump walk hold until o_out.ready returns.
`default_nettype none

module bounded_doubly_linked_list import bdll_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdll_in_if.sink    i_in,
    bdll_out_if.source o_out
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    // sequencer
    bdll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // node pool, links and output register
    bdll_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_command   (i_in.command),
        .i_key       (i_in.key),
        .i_value     (i_in.value),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_status    (o_out.status),
        .o_item      (o_out.item),
        .o_last      (o_out.last)
    );

endmodule

`default_nettype wire

// File: dv/bounded_doubly_linked_list_test.sv
`timescale 1ns / 100ps

module bounded_doubly_linked_list_test;
    import bdll_pkg::*;

    localparam int POOL_SIZE    = CAPACITY_DEF;
    localparam int DUMP_LIMIT   = (POOL_SIZE < MAX_RESULTS) ? POOL_SIZE : MAX_RESULTS;
    localparam int RANDOM_CMDS  = 155;
    localparam int HOT_COUNT    = 12;
    localparam int HOLD_AT      = 75;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SHOW_FAULTS  = 10;

    typedef struct {
        t_cmd               cmd;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_cmd_item;

    typedef struct {
        t_status            status;
        logic signed [31:0] item;
        logic               last;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    bdll_in_if  cmd_ch ();
    bdll_out_if reply_ch ();

    bounded_doubly_linked_list #(
        .CAPACITY (POOL_SIZE)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (reply_ch)
    );

    t_cmd_item          cmd_backlog[$];
    t_reply             predicted_replies[$];
    logic signed [31:0] list_model[$];
    logic signed [31:0] hot_vals[HOT_COUNT];

    t_cmd_item next_cmd;
    t_reply    head_reply;
    int        send_gap      = 0;
    int        recv_gap      = 0;
    int        cmds_total    = 0;
    int        cmds_accepted = 0;
    int        fault_count   = 0;
    int        cycle_count   = 0;
    logic      no_idle       = 1'b0;
    logic      long_hold     = 1'b0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reset and known input levels from time zero
    initial begin
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_APPEND;
        cmd_ch.key     = '0;
        cmd_ch.value   = '0;
        reply_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // idle length: mostly short, a few long, none during calm stretches
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // values mostly from a small hot set so that keys hit list entries
    function automatic logic signed [31:0] draw_value();
        if ($urandom_range(0, 99) < 80) return hot_vals[$urandom_range(0, HOT_COUNT - 1)];
        return $urandom;
    endfunction

    function automatic void queue_cmd(input t_cmd cmd, input logic signed [31:0] key,
                                      input logic signed [31:0] value);
        t_cmd_item c;
        c.cmd   = cmd;
        c.key   = key;
        c.value = value;
        cmd_backlog.push_back(c);
    endfunction

    function automatic void post_reply(input t_status st, input logic signed [31:0] val,
                                       input logic fin);
        t_reply r;
        r.status = st;
        r.item   = val;
        r.last   = fin;
        predicted_replies.push_back(r);
    endfunction

    // list behavior: apply one command to the value list and queue its replies
    task automatic apply_list_command(input t_cmd cmd, input logic signed [31:0] key,
                                      input logic signed [31:0] value);
        int hit;
        int n_out;
        hit = -1;
        if (cmd == CMD_INSERT || cmd == CMD_DELETE) begin
            for (int i = 0; i < list_model.size(); i++)
                if (hit < 0 && list_model[i] == key) hit = i;
        end
        case (cmd)
            CMD_APPEND: begin
                if (list_model.size() >= POOL_SIZE) begin
                    post_reply(ST_FULL, '0, 1'b1);
                end else begin
                    list_model.push_back(value);
                    post_reply(ST_OK, '0, 1'b1);
                end
            end
            // search comes before the full check
            CMD_INSERT: begin
                if (hit < 0) begin
                    post_reply(ST_NOT_FOUND, '0, 1'b1);
                end else if (list_model.size() >= POOL_SIZE) begin
                    post_reply(ST_FULL, '0, 1'b1);
                end else begin
                    list_model.insert(hit, value);
                    post_reply(ST_OK, '0, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (hit < 0) begin
                    post_reply(ST_NOT_FOUND, '0, 1'b1);
                end else begin
                    list_model.delete(hit);
                    post_reply(ST_OK, '0, 1'b1);
                end
            end
            CMD_DUMP: begin
                if (list_model.size() == 0) begin
                    post_reply(ST_EMPTY, '0, 1'b1);
                end else begin
                    n_out = (list_model.size() < DUMP_LIMIT) ?
                            list_model.size() : DUMP_LIMIT;
                    for (int k = 0; k < n_out; k++)
                        post_reply(ST_OK, list_model[k], k == n_out - 1);
                end
            end
        endcase
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (send_gap > 0) begin
                cmd_ch.valid <= 1'b0;
                send_gap--;
            end else if (cmd_backlog.size() > 0) begin
                next_cmd = cmd_backlog.pop_front();
                cmd_ch.valid   <= 1'b1;
                cmd_ch.command <= next_cmd.cmd;
                cmd_ch.key     <= next_cmd.key;
                cmd_ch.value   <= next_cmd.value;
                send_gap = draw_gap();
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // reply receiver with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n || long_hold) begin
            reply_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            reply_ch.ready <= 1'b0;
            recv_gap--;
        end else begin
            reply_ch.ready <= 1'b1;
            recv_gap = draw_gap();
        end
    end

    // monitor: predict on accepted commands, check accepted replies
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                apply_list_command(t_cmd'(cmd_ch.command), cmd_ch.key, cmd_ch.value);
                cmds_accepted++;
            end
            if (reply_ch.valid && reply_ch.ready) begin
                if (predicted_replies.size() == 0) begin
                    fault_count++;
                    if (fault_count <= SHOW_FAULTS)
                        $display("unexpected reply: status %0d item %0d last %0d",
                                 reply_ch.status, reply_ch.item, reply_ch.last);
                end else begin
                    head_reply = predicted_replies.pop_front();
                    if (reply_ch.status !== head_reply.status ||
                        reply_ch.item !== head_reply.item ||
                        reply_ch.last !== head_reply.last) begin
                        fault_count++;
                        if (fault_count <= SHOW_FAULTS)
                            $display({"reply mismatch: expected status %0d item %0d ",
                                      "last %0d, got status %0d item %0d last %0d"},
                                     head_reply.status, head_reply.item, head_reply.last,
                                     reply_ch.status, reply_ch.item, reply_ch.last);
                    end
                end
            end
        end
    end

    // long receiver hold-off while commands keep coming
    initial begin
        while (cmds_accepted < HOLD_AT) @(negedge i_clk);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // cycle counter: calm stretches and the run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count % 256 == 0) no_idle <= ($urandom_range(0, 3) == 0);
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus and end of run
    initial begin
        int   roll;
        t_cmd pick;
        logic fill_phase;

        hot_vals[0] = 32'sh8000_0000;
        hot_vals[1] = 32'sh7fff_ffff;
        hot_vals[2] = 32'sh0000_0000;
        hot_vals[3] = -32'sd1;
        for (int i = 4; i < HOT_COUNT; i++) hot_vals[i] = $urandom;

        // empty list: dump and key absent
        queue_cmd(CMD_DUMP, 0, 0);
        queue_cmd(CMD_DELETE, 32'sd7, 0);
        // extreme values at the tail
        queue_cmd(CMD_APPEND, 0, 32'sh8000_0000);
        queue_cmd(CMD_APPEND, 0, 32'sh7fff_ffff);
        queue_cmd(CMD_APPEND, 0, 32'sh0000_0000);
        queue_cmd(CMD_APPEND, 0, -32'sd1);
        // insert as new head, in the middle, and with key absent
        queue_cmd(CMD_INSERT, 32'sh8000_0000, 32'sd100);
        queue_cmd(CMD_INSERT, 32'sh0000_0000, 32'sh5555_5555);
        queue_cmd(CMD_INSERT, 32'sd12345, 32'sd1);
        // fill the pool, with a duplicate value first
        queue_cmd(CMD_APPEND, 32'sh7fff_ffff, 32'sh0000_0000);
        for (int i = 1; i < 10; i++) queue_cmd(CMD_APPEND, 0, 32'sha5a5_0000 | i);
        // pool full on append and on insert; key absent while full
        queue_cmd(CMD_APPEND, 0, 32'sd1);
        queue_cmd(CMD_INSERT, -32'sd1, 32'sd2);
        queue_cmd(CMD_INSERT, 32'sd777, 32'sd3);
        queue_cmd(CMD_DUMP, 0, 0);
        // delete first of duplicates, then the tail
        queue_cmd(CMD_DELETE, 32'sh0000_0000, 0);
        queue_cmd(CMD_DELETE, 32'sha5a5_0009, 0);

        // random part: alternate fill-heavy and drain-heavy stretches
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            fill_phase = ((i / 30) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (fill_phase)
                pick = (roll < 55) ? CMD_APPEND : (roll < 75) ? CMD_INSERT :
                       (roll < 85) ? CMD_DELETE : CMD_DUMP;
            else
                pick = (roll < 15) ? CMD_APPEND : (roll < 25) ? CMD_INSERT :
                       (roll < 85) ? CMD_DELETE : CMD_DUMP;
            queue_cmd(pick, draw_value(), draw_value());
        end
        cmds_total = cmd_backlog.size();

        while (cmds_accepted < cmds_total || predicted_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        fault_count += predicted_replies.size();
        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
design/bdll_pkg.sv
design/bdll_if.sv
design/bdll_dp.sv
design/bdll_ctrl.sv
design/bounded_doubly_linked_list.sv
dv/bounded_doubly_linked_list_test.sv
